### rtl/core/haar_wavelet_2d_multilevel_unit_macros.svh
`ifndef HAAR_WAVELET_2D_MULTILEVEL_UNIT_MACROS_SVH
`define HAAR_WAVELET_2D_MULTILEVEL_UNIT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off while in reset.
`define HW2D_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("hw2d assertion failed");

// Next-cycle implication, clocked on aclk, off while in reset.
`define HW2D_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("hw2d assertion failed");

`endif

### rtl/core/hw2d_pkg.sv
package hw2d_pkg;

    localparam int SIDE_LOG2  = 8;
    localparam int IMAGE_SIDE = 1 << SIDE_LOG2;
    localparam int AREA       = IMAGE_SIDE * IMAGE_SIDE;
    localparam int MEM_AW     = 2 * SIDE_LOG2;
    localparam int PIX_W      = 8;
    localparam int PADDR_W    = 16;
    localparam int LVL_W      = 4;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [SIDE_LOG2-1:0] SIDE_HALF  = SIDE_LOG2'(IMAGE_SIDE / 2);
    localparam logic [SIDE_LOG2-1:0] SIDE_LAST  = SIDE_LOG2'(IMAGE_SIDE - 1);
    localparam logic [LVL_W-1:0]     LVL_LIMIT  = LVL_W'(SIDE_LOG2);
    localparam logic [LVL_W-1:0]     LVL_RESET  = LVL_W'(1);

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_RUN  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    localparam logic REG_LEVEL_COUNT = 1'b0;

    typedef struct packed {
        logic [1:0]         action;
        logic [PADDR_W-1:0] pixel_address;
        logic [PIX_W-1:0]   pixel_value;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] read_value;
        logic             run_done;
    } out_item_t;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_READ,
        OUT_DONE
    } out_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LEVEL,
        ST_RD_A,
        ST_RD_B,
        ST_WR_LO,
        ST_WR_HI
    } state_t;

    typedef struct packed {
        logic     host_sel;
        logic     host_load;
        logic     host_read;
        logic     run_init;
        logic     rd_b;
        logic     cap_a;
        logic     cap_b;
        logic     wr_low;
        logic     wr_high;
        logic     step;
        logic     out_load;
        out_sel_t out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
        logic pass_end;
        logic pass_col;
        logic levels_done;
    } dp_status_t;

    function automatic logic [PIX_W-1:0] low_of(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        logic [PIX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b} + (PIX_W+1)'(1);
        return sum[PIX_W:1];
    endfunction

    // 128 + (a-b)/2 rounded half away from zero, clipped at 255
    function automatic logic [PIX_W-1:0] high_of(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [PIX_W:0]   d;
        logic [PIX_W+1:0] r;
        if (a >= b) begin
            d = {1'b0, a} - {1'b0, b} + (PIX_W+1)'(1);
            r = (PIX_W+2)'(128) + {2'b00, d[PIX_W:1]};
        end else begin
            d = {1'b0, b} - {1'b0, a} + (PIX_W+1)'(1);
            r = (PIX_W+2)'(128) - {2'b00, d[PIX_W:1]};
        end
        if (r > (PIX_W+2)'(255)) begin
            r = (PIX_W+2)'(255);
        end
        return r[PIX_W-1:0];
    endfunction

endpackage

### rtl/core/hw2d_ram.sv
module hw2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/hw2d_ctrl.sv
module hw2d_ctrl
    import hw2d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] action,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && !status.out_busy;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_sel = OUT_ZERO;
        case (state_reg)
            ST_IDLE: begin
                cmd.host_sel = 1'b1;
                if (accept) begin
                    case (action)
                        ACT_LOAD: begin
                            cmd.host_load = 1'b1;
                            cmd.out_load  = 1'b1;
                        end
                        ACT_RUN: begin
                            cmd.run_init = 1'b1;
                            state_next   = ST_LEVEL;
                        end
                        ACT_READ: begin
                            cmd.host_read = 1'b1;
                            state_next    = ST_READ;
                        end
                        default: begin
                            cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = OUT_READ;
                state_next   = ST_IDLE;
            end
            ST_LEVEL: begin
                if (status.levels_done) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_DONE;
                    state_next   = ST_IDLE;
                end else begin
                    state_next = ST_RD_A;
                end
            end
            ST_RD_A: begin
                state_next = ST_RD_B;
            end
            ST_RD_B: begin
                cmd.rd_b   = 1'b1;
                cmd.cap_a  = 1'b1;
                state_next = ST_WR_LO;
            end
            ST_WR_LO: begin
                cmd.cap_b  = 1'b1;
                cmd.wr_low = 1'b1;
                state_next = ST_WR_HI;
            end
            ST_WR_HI: begin
                cmd.wr_high = 1'b1;
                cmd.step    = 1'b1;
                if (status.pass_end && status.pass_col) begin
                    state_next = ST_LEVEL;
                end else begin
                    state_next = ST_RD_A;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/hw2d_dp.sv
module hw2d_dp
    import hw2d_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  in_item_t         s_data,
    input  logic [LVL_W-1:0] level_count,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data
);

    logic [LVL_W-1:0]     lvl_reg;
    logic [LVL_W-1:0]     target_reg;
    logic [SIDE_LOG2-1:0] line_reg;
    logic [SIDE_LOG2-1:0] pair_reg;
    logic                 pass_col_reg;
    logic [PIX_W-1:0]     a_reg;
    logic [PIX_W-1:0]     b_reg;
    logic                 in_rng_reg;
    logic                 m_valid_reg;
    out_item_t            m_data_reg;
    out_item_t            m_data_next;

    logic [SIDE_LOG2-1:0] half;
    logic [SIDE_LOG2-1:0] half_m1;
    logic [SIDE_LOG2-1:0] side_m1;
    logic [SIDE_LOG2-1:0] pair_x2;
    logic [SIDE_LOG2-1:0] pair_hi;
    logic                 pair_last;
    logic                 line_last;
    logic                 in_rng;

    logic [MEM_AW-1:0] addr_a;
    logic [MEM_AW-1:0] addr_b;
    logic [MEM_AW-1:0] addr_lo;
    logic [MEM_AW-1:0] addr_hi;
    logic [MEM_AW-1:0] pass_raddr;
    logic [MEM_AW-1:0] pass_waddr;
    logic [PIX_W-1:0]  pass_wdata;
    logic [PIX_W-1:0]  rd_now;

    logic              img_we;
    logic [MEM_AW-1:0] img_waddr;
    logic [PIX_W-1:0]  img_wdata;
    logic [MEM_AW-1:0] img_raddr;
    logic [PIX_W-1:0]  img_rdata;
    logic              scr_we;
    logic [PIX_W-1:0]  scr_rdata;

    // current level geometry
    assign half      = SIDE_HALF >> lvl_reg;
    assign half_m1   = half - SIDE_LOG2'(1);
    assign side_m1   = SIDE_LAST >> lvl_reg;
    assign pair_x2   = {pair_reg[SIDE_LOG2-2:0], 1'b0};
    assign pair_hi   = half + pair_reg;
    assign pair_last = (pair_reg == half_m1);
    assign line_last = (line_reg == side_m1);
    assign in_rng    = (32'(s_data.pixel_address) < 32'(AREA));

    // row pass pairs along a row, column pass pairs down a column
    always_comb begin
        if (pass_col_reg) begin
            addr_a  = {pair_x2, line_reg};
            addr_b  = {pair_x2 | SIDE_LOG2'(1), line_reg};
            addr_lo = {pair_reg, line_reg};
            addr_hi = {pair_hi, line_reg};
        end else begin
            addr_a  = {line_reg, pair_x2};
            addr_b  = {line_reg, pair_x2 | SIDE_LOG2'(1)};
            addr_lo = {line_reg, pair_reg};
            addr_hi = {line_reg, pair_hi};
        end
    end

    assign pass_raddr = cmd.rd_b ? addr_b : addr_a;
    assign pass_waddr = cmd.wr_low ? addr_lo : addr_hi;
    assign rd_now     = pass_col_reg ? scr_rdata : img_rdata;
    assign pass_wdata = cmd.wr_low ? low_of(a_reg, rd_now) : high_of(a_reg, b_reg);

    assign img_raddr = cmd.host_sel ? s_data.pixel_address[MEM_AW-1:0] : pass_raddr;
    assign img_we    = (cmd.host_load && in_rng) ||
                       ((cmd.wr_low || cmd.wr_high) && pass_col_reg);
    assign img_waddr = cmd.host_load ? s_data.pixel_address[MEM_AW-1:0] : pass_waddr;
    assign img_wdata = cmd.host_load ? s_data.pixel_value : pass_wdata;
    assign scr_we    = (cmd.wr_low || cmd.wr_high) && !pass_col_reg;

    hw2d_ram #(
        .WIDTH (PIX_W),
        .DEPTH (AREA)
    ) u_image (
        .aclk  (aclk),
        .we    (img_we),
        .waddr (img_waddr),
        .wdata (img_wdata),
        .raddr (img_raddr),
        .rdata (img_rdata)
    );

    hw2d_ram #(
        .WIDTH (PIX_W),
        .DEPTH (AREA)
    ) u_scratch (
        .aclk  (aclk),
        .we    (scr_we),
        .waddr (pass_waddr),
        .wdata (pass_wdata),
        .raddr (pass_raddr),
        .rdata (scr_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_reg      <= '0;
            target_reg   <= '0;
            line_reg     <= '0;
            pair_reg     <= '0;
            pass_col_reg <= 1'b0;
        end else if (cmd.run_init) begin
            lvl_reg      <= '0;
            target_reg   <= (level_count > LVL_LIMIT) ? LVL_LIMIT : level_count;
            line_reg     <= '0;
            pair_reg     <= '0;
            pass_col_reg <= 1'b0;
        end else if (cmd.step) begin
            if (pair_last) begin
                pair_reg <= '0;
                if (line_last) begin
                    line_reg     <= '0;
                    pass_col_reg <= !pass_col_reg;
                    if (pass_col_reg) begin
                        lvl_reg <= lvl_reg + LVL_W'(1);
                    end
                end else begin
                    line_reg <= line_reg + SIDE_LOG2'(1);
                end
            end else begin
                pair_reg <= pair_reg + SIDE_LOG2'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_a) begin
            a_reg <= rd_now;
        end
        if (cmd.cap_b) begin
            b_reg <= rd_now;
        end
        if (cmd.host_read) begin
            in_rng_reg <= in_rng;
        end
    end

    always_comb begin
        m_data_next = '0;
        case (cmd.out_sel)
            OUT_READ: m_data_next.read_value = in_rng_reg ? img_rdata : '0;
            OUT_DONE: m_data_next.run_done   = 1'b1;
            default:  m_data_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.out_busy    = m_valid_reg && !m_ready;
    assign status.pass_end    = pair_last && line_last;
    assign status.pass_col    = pass_col_reg;
    assign status.levels_done = (lvl_reg == target_reg);

endmodule

### rtl/core/haar_wavelet_2d_multilevel_unit.sv
// Multi-level 2D Haar transform over a 256x256 byte image held in on-chip RAM.
// Load and read beats address the image in raster order (row * 256 + column).
// A load writes the RAM while its answer is registered; a read registers the
// RAM data and then the result. A run beat transforms the image in place over
// min(level_count, 8) levels and answers with run_done once finished: each
// level makes a row pass into the scratch RAM and a column pass back; each
// pixel pair steps through ST_RD_A, ST_RD_B, ST_WR_LO and ST_WR_HI, set by the
// single read and write port of each RAM. No input beat is taken while a run
// is active.
`include "haar_wavelet_2d_multilevel_unit_macros.svh"

module haar_wavelet_2d_multilevel_unit
    import hw2d_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [LVL_W-1:0] level_count_reg;
    logic             cfg_wr;
    dp_cmd_t          cmd;
    dp_status_t       status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LEVEL_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_count_reg <= LVL_RESET;
        end else if (cfg_wr) begin
            level_count_reg <= pwdata[LVL_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_LEVEL_COUNT) ?
                    {{(APB_DW-LVL_W){1'b0}}, level_count_reg} : '0;

    hw2d_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .action  (s_data.action),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    hw2d_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .level_count (level_count_reg),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // a run holds off the next beat
    `HW2D_ASSERT_NEXT(a_run_blocks, s_valid && s_ready && (s_data.action == ACT_RUN), !s_ready)
    // a read fetches from the RAM, then presents its result
    `HW2D_ASSERT_NEXT(a_read_timing, s_valid && s_ready && (s_data.action == ACT_READ), !m_valid ##1 m_valid)
    `HW2D_ASSERT_NOW(a_done_zero, m_valid && m_data.run_done, m_data.read_value == '0)
    `HW2D_ASSERT_NEXT(a_cfg_write, cfg_wr, level_count_reg == $past(pwdata[LVL_W-1:0]))

endmodule
